FILE: rtl/core/integer_decimal_formatter_macros.svh
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_DECIMAL_FORMATTER_MACROS_SVH
`define INTEGER_DECIMAL_FORMATTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/idf_pkg.sv
package idf_pkg;

   localparam int unsigned MAX_DIGITS_DEF = 10;
   localparam int unsigned BCD_DIGITS     = 10;
   localparam int unsigned VALUE_W        = 32;
   localparam int unsigned CODE_W         = 16;
   localparam int unsigned CAP_W          = 8;
   localparam int unsigned COUNT_W        = 4;
   localparam int unsigned MODE_W         = 2;
   localparam int unsigned CSR_IDX_W      = 3;
   localparam int unsigned DIGIT_W        = 4;
   localparam int unsigned POS_W          = $clog2(BCD_DIGITS);
   localparam int unsigned STEP_W         = $clog2(VALUE_W);

   localparam logic [MODE_W-1:0] ALIGN_RIGHT = 2'd1;
   localparam logic [MODE_W-1:0] ALIGN_ZEROS = 2'd2;

   localparam logic [CAP_W-1:0]  CAPACITY_RST   = 8'd12;
   localparam logic [CODE_W-1:0] JP_ZERO_RST    = 16'd0;
   localparam logic [CODE_W-1:0] EN_ZERO_RST    = 16'd48;
   localparam logic [CODE_W-1:0] JP_HYPHEN_RST  = 16'd0;
   localparam logic [CODE_W-1:0] EN_HYPHEN_RST  = 16'd45;
   localparam logic [CODE_W-1:0] JP_SPACE_RST   = 16'd0;
   localparam logic [CODE_W-1:0] EN_SPACE_RST   = 16'd32;
   localparam logic [CODE_W-1:0] OVERFLOW_RST   = 16'd63;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY,
      CSR_JP_ZERO,
      CSR_EN_ZERO,
      CSR_JP_HYPHEN,
      CSR_EN_HYPHEN,
      CSR_JP_SPACE,
      CSR_EN_SPACE,
      CSR_OVERFLOW
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/core/integer_decimal_formatter.sv
// Channel   Handshake            Beat contents
// req       req_valid/req_stall  value, digit count, alignment mode, character set
// rsp       rsp_valid/rsp_stall  one character code with last and error marks
// csr       csr_write            register index and data
//
// An item is taken and then converted by a shift-and-add-three loop, one magnitude
// bit a cycle, unless it fails the capacity check.
// Emission then covers one digit position a cycle, after a hyphen for a negative
// value, while the result side does not stall.
// Reset is synchronous and restores the register defaults; stalls on the result
// side hold emission, and a new item is taken while the final beat still waits.
`include "integer_decimal_formatter_macros.svh"

module integer_decimal_formatter #(
   parameter int unsigned MAX_DIGITS = idf_pkg::MAX_DIGITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [idf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [idf_pkg::CODE_W-1:0]           csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [idf_pkg::VALUE_W-1:0]   req_value,
   input  logic [idf_pkg::COUNT_W-1:0]          req_digit_count,
   input  logic [idf_pkg::MODE_W-1:0]           req_align_mode,
   input  logic                                 req_char_set,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [idf_pkg::CODE_W-1:0]           rsp_char_code,
   output logic                                 rsp_last,
   output logic                                 rsp_error
);
   import idf_pkg::*;

   state_type                 state_ff, state_in;
   logic [STEP_W-1:0]         step_ff;
   logic [VALUE_W-1:0]        bin_ff;
   logic [DIGIT_W-1:0]        bcd_ff [BCD_DIGITS];
   logic [DIGIT_W-1:0]        bcd_in [BCD_DIGITS];
   logic [COUNT_W-1:0]        n_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [MODE_W-1:0]         mode_ff;
   logic                      set_ff, hyph_ff, err_ff, printing_ff;

   logic [CAP_W-1:0]          capacity_ff;
   logic [CODE_W-1:0]         jp_zero_ff, en_zero_ff, jp_hyphen_ff, en_hyphen_ff;
   logic [CODE_W-1:0]         jp_space_ff, en_space_ff, overflow_ff;

   logic                      rsp_valid_ff;
   logic [CODE_W-1:0]         rsp_code_ff;
   logic                      rsp_last_ff, rsp_error_ff;

   logic                      accept, neg, err_now, out_free, step;
   logic [VALUE_W-1:0]        raw, mag;
   logic [COUNT_W-1:0]        n_clamped;
   logic [DIGIT_W-1:0]        adj [BCD_DIGITS];
   logic                      ovf, top, q_ovf, show;
   logic [DIGIT_W-1:0]        digit;
   logic [CODE_W-1:0]         zero_code, digit_code;
   logic                      load_out, out_last, out_err, pos_dec, hyph_done;
   logic [CODE_W-1:0]         out_code;

   // Input decode and capacity check.
   always_comb begin
      raw = VALUE_W'(req_value);
      neg = raw[VALUE_W-1];
      mag = neg ? (VALUE_W'(0) - raw) : raw;
      if (req_digit_count == '0) begin
         n_clamped = COUNT_W'(1);
      end else if (req_digit_count > COUNT_W'(MAX_DIGITS)) begin
         n_clamped = COUNT_W'(MAX_DIGITS);
      end else begin
         n_clamped = req_digit_count;
      end
      err_now = capacity_ff <= (CAP_W'(n_clamped) + CAP_W'(neg));
   end

   // One shift-and-add-three step of the binary to decimal conversion.
   always_comb begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
         adj[k] = (bcd_ff[k] >= DIGIT_W'(5)) ? (bcd_ff[k] + DIGIT_W'(3)) : bcd_ff[k];
      end
      for (int k = 0; k < BCD_DIGITS; k++) begin
         if (k == 0) begin
            bcd_in[k] = {adj[k][DIGIT_W-2:0], bin_ff[VALUE_W-1]};
         end else begin
            bcd_in[k] = {adj[k][DIGIT_W-2:0], adj[k-1][DIGIT_W-1]};
         end
      end
   end

   // Character selection for the current position.
   always_comb begin
      ovf = 1'b0;
      for (int k = 0; k < BCD_DIGITS; k++) begin
         if ((COUNT_W'(k) >= n_ff) && (bcd_ff[k] != '0)) begin
            ovf = 1'b1;
         end
      end
      top        = pos_ff == POS_W'(n_ff - COUNT_W'(1));
      q_ovf      = top && ovf;
      digit      = bcd_ff[pos_ff];
      show       = printing_ff || (mode_ff == ALIGN_ZEROS) || q_ovf || (digit != '0)
                   || (pos_ff == '0);
      zero_code  = set_ff ? en_zero_ff : jp_zero_ff;
      digit_code = zero_code + CODE_W'(digit);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = err_now ? ST_EMIT : ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (step && (err_ff || (!hyph_ff && (pos_ff == '0)))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = state_ff != ST_IDLE;
      accept    = (state_ff == ST_IDLE) && req_valid;
      out_free  = !rsp_valid_ff || !rsp_stall;
      step      = (state_ff == ST_EMIT) && out_free;
      load_out  = 1'b0;
      out_code  = '0;
      out_last  = 1'b0;
      out_err   = 1'b0;
      pos_dec   = 1'b0;
      hyph_done = 1'b0;
      if (step) begin
         if (err_ff) begin
            load_out = 1'b1;
            out_last = 1'b1;
            out_err  = 1'b1;
         end else if (hyph_ff) begin
            load_out  = 1'b1;
            out_code  = set_ff ? en_hyphen_ff : jp_hyphen_ff;
            hyph_done = 1'b1;
         end else if (show) begin
            load_out = 1'b1;
            out_code = q_ovf ? overflow_ff : digit_code;
            out_last = pos_ff == '0;
            pos_dec  = 1'b1;
         end else if (mode_ff == ALIGN_RIGHT) begin
            load_out = 1'b1;
            out_code = set_ff ? en_space_ff : jp_space_ff;
            pos_dec  = 1'b1;
         end else begin
            pos_dec = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAPACITY_RST;
         jp_zero_ff   <= JP_ZERO_RST;
         en_zero_ff   <= EN_ZERO_RST;
         jp_hyphen_ff <= JP_HYPHEN_RST;
         en_hyphen_ff <= EN_HYPHEN_RST;
         jp_space_ff  <= JP_SPACE_RST;
         en_space_ff  <= EN_SPACE_RST;
         overflow_ff  <= OVERFLOW_RST;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_CAPACITY:  capacity_ff  <= csr_data[CAP_W-1:0];
               CSR_JP_ZERO:   jp_zero_ff   <= csr_data;
               CSR_EN_ZERO:   en_zero_ff   <= csr_data;
               CSR_JP_HYPHEN: jp_hyphen_ff <= csr_data;
               CSR_EN_HYPHEN: en_hyphen_ff <= csr_data;
               CSR_JP_SPACE:  jp_space_ff  <= csr_data;
               CSR_EN_SPACE:  en_space_ff  <= csr_data;
               CSR_OVERFLOW:  overflow_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bin_ff      <= mag;
         step_ff     <= '0;
         n_ff        <= n_clamped;
         pos_ff      <= POS_W'(n_clamped - COUNT_W'(1));
         mode_ff     <= req_align_mode;
         set_ff      <= req_char_set;
         hyph_ff     <= neg;
         err_ff      <= err_now;
         printing_ff <= 1'b0;
         for (int k = 0; k < BCD_DIGITS; k++) begin
            bcd_ff[k] <= '0;
         end
      end else if (state_ff == ST_CONVERT) begin
         bin_ff  <= {bin_ff[VALUE_W-2:0], 1'b0};
         step_ff <= step_ff + STEP_W'(1);
         bcd_ff  <= bcd_in;
      end else begin
         if (hyph_done) begin
            hyph_ff <= 1'b0;
         end
         if (pos_dec) begin
            pos_ff <= pos_ff - POS_W'(1);
            if (show) begin
               printing_ff <= 1'b1;
            end
         end
      end
      if (load_out) begin
         rsp_code_ff  <= out_code;
         rsp_last_ff  <= out_last;
         rsp_error_ff <= out_err;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_code_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_error     = rsp_error_ff;

   `IDF_ASSERT_NEXT(a_err_skips_convert, clock, reset, accept && err_now,
      (state_ff == ST_EMIT) && err_ff, "capacity failure did not go straight to emission")
   `IDF_ASSERT_NOW(a_err_beat_shape, clock, reset, rsp_valid && rsp_error,
      rsp_last && (rsp_char_code == '0), "error beat is not a lone last beat")
   `IDF_ASSERT_NEXT(a_convert_length, clock, reset,
      (state_ff == ST_CONVERT) && (step_ff == STEP_W'(VALUE_W - 1)),
      (state_ff == ST_EMIT) && (bin_ff == '0), "conversion did not end after all bits")
   `IDF_ASSERT_NEXT(a_last_ends_item, clock, reset, load_out && out_last,
      state_ff == ST_IDLE, "item continued after its last beat")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import idf_pkg::*;

   localparam int unsigned MAX_DIGITS = MAX_DIGITS_DEF;
   localparam logic [MODE_W-1:0] ALIGN_LEFT = 2'd0;
   localparam logic [MODE_W-1:0] ALIGN_LEFT_ALT = 2'd3;
   localparam logic SET_JP = 1'b0;
   localparam logic SET_EN = 1'b1;
   localparam int unsigned LIMIT_CYCLES = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned NUM_PHASES = 4;
   localparam int unsigned ITEMS_PER_PHASE = 23;
   localparam int unsigned NUM_ROWS = 24;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_TEXT,
      ROW_ERROR,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [COUNT_W-1:0]        count;
      logic [MODE_W-1:0]         mode;
      logic                      set;
   } format_request_type;

   typedef struct {
      row_kind_type       kind;
      format_request_type request;
      logic [8*11-1:0]    text;
      csr_index_type      index;
      logic [CODE_W-1:0]  data;
   } row_type;

   typedef struct {
      logic [CODE_W-1:0] code;
      logic              last;
      logic              error;
   } char_beat_type;

   localparam format_request_type NO_REQUEST = '{0, 0, ALIGN_LEFT, SET_JP};

   // Values that are typed in are written as ASCII and need the reset codes of set 1.
   row_type directed_rows [NUM_ROWS] = '{
      '{ROW_TEXT, '{0, 1, ALIGN_LEFT, SET_EN}, "0", CSR_CAPACITY, '0},
      '{ROW_TEXT, '{0, 10, ALIGN_ZEROS, SET_EN}, "0000000000", CSR_CAPACITY, '0},
      '{ROW_TEXT, '{0, 10, ALIGN_RIGHT, SET_EN}, "         0", CSR_CAPACITY, '0},
      '{ROW_TEXT, '{32'sh7FFF_FFFF, 10, ALIGN_LEFT, SET_EN}, "2147483647", CSR_CAPACITY, '0},
      '{ROW_TEXT, '{32'sh8000_0000, 10, ALIGN_LEFT, SET_EN}, "-2147483648", CSR_CAPACITY,
        '0},
      '{ROW_TEXT, '{-1, 3, ALIGN_RIGHT, SET_EN}, "-  1", CSR_CAPACITY, '0},
      '{ROW_TEXT, '{12345, 3, ALIGN_LEFT, SET_EN}, "?45", CSR_CAPACITY, '0},
      '{ROW_TEXT, '{42, 0, ALIGN_ZEROS, SET_EN}, "?", CSR_CAPACITY, '0},
      '{ROW_TEXT, '{7, 15, ALIGN_ZEROS, SET_EN}, "0000000007", CSR_CAPACITY, '0},
      '{ROW_TEXT, '{305, 5, ALIGN_LEFT_ALT, SET_EN}, "305", CSR_CAPACITY, '0},
      '{ROW_TEXT, '{-305, 5, ALIGN_RIGHT, SET_EN}, "-  305", CSR_CAPACITY, '0},
      '{ROW_TEXT, '{1000000000, 10, ALIGN_LEFT, SET_EN}, "1000000000", CSR_CAPACITY, '0},
      '{ROW_PREDICT, '{123, 4, ALIGN_RIGHT, SET_JP}, '0, CSR_CAPACITY, '0},
      '{ROW_PREDICT, '{-9, 2, ALIGN_ZEROS, SET_JP}, '0, CSR_CAPACITY, '0},
      '{ROW_WRITE, NO_REQUEST, '0, CSR_JP_ZERO, 16'hFFFB},
      '{ROW_WRITE, NO_REQUEST, '0, CSR_JP_HYPHEN, 16'hFFFF},
      '{ROW_PREDICT, '{-987654321, 10, ALIGN_ZEROS, SET_JP}, '0, CSR_CAPACITY, '0},
      '{ROW_WRITE, NO_REQUEST, '0, CSR_CAPACITY, 16'hFF00},
      '{ROW_ERROR, '{5, 1, ALIGN_LEFT, SET_EN}, '0, CSR_CAPACITY, '0},
      '{ROW_WRITE, NO_REQUEST, '0, CSR_CAPACITY, 16'd11},
      '{ROW_ERROR, '{-1, 10, ALIGN_RIGHT, SET_EN}, '0, CSR_CAPACITY, '0},
      '{ROW_PREDICT, '{1, 10, ALIGN_RIGHT, SET_JP}, '0, CSR_CAPACITY, '0},
      '{ROW_ERROR, '{-7, 15, ALIGN_ZEROS, SET_JP}, '0, CSR_CAPACITY, '0},
      '{ROW_WRITE, NO_REQUEST, '0, CSR_CAPACITY, 16'hFFFF}
   };

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      csr_write = 1'b0;
   csr_index_type             csr_index = CSR_CAPACITY;
   logic [CODE_W-1:0]         csr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [COUNT_W-1:0]        req_digit_count = '0;
   logic [MODE_W-1:0]         req_align_mode = '0;
   logic                      req_char_set = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [CODE_W-1:0]         rsp_char_code;
   logic                      rsp_last;
   logic                      rsp_error;

   logic [CAP_W-1:0]  capacity_reg;
   logic [CODE_W-1:0] zero_code [2];
   logic [CODE_W-1:0] hyphen_code [2];
   logic [CODE_W-1:0] space_code [2];
   logic [CODE_W-1:0] overflow_reg;

   char_beat_type awaited_chars [$];
   int unsigned   fault_count = 0;
   bit            steady = 1'b0;
   bit            pressure_due = 1'b0;

   integer_decimal_formatter #(
      .MAX_DIGITS(MAX_DIGITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_digit_count(req_digit_count),
      .req_align_mode(req_align_mode),
      .req_char_set(req_char_set),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_code(rsp_char_code),
      .rsp_last(rsp_last),
      .rsp_error(rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void expect_chars(input logic [CODE_W-1:0] codes [$]);
      char_beat_type b;
      foreach (codes[k]) begin
         b.code = codes[k];
         b.last = (k == codes.size() - 1);
         b.error = 1'b0;
         awaited_chars.push_back(b);
      end
   endfunction

   function automatic void expect_overflow_error();
      char_beat_type b;
      b.code = '0;
      b.last = 1'b1;
      b.error = 1'b1;
      awaited_chars.push_back(b);
   endfunction

   function automatic void format_decimal(input format_request_type r);
      logic [CODE_W-1:0] codes [$];
      logic [VALUE_W-1:0] mag;
      logic neg;
      logic showing;
      int n;
      int pos;
      int unsigned p;
      int unsigned q;
      neg = r.value[VALUE_W-1];
      mag = neg ? 32'd0 - r.value : r.value;
      n = r.count;
      if (n < 1) n = 1;
      if (n > MAX_DIGITS) n = MAX_DIGITS;
      if (capacity_reg <= n + neg) begin
         expect_overflow_error();
         return;
      end
      if (neg) codes.push_back(hyphen_code[r.set]);
      showing = (r.mode == ALIGN_ZEROS);
      p = 1;
      for (pos = 1; pos < n; pos++) p = p * 10;
      for (pos = n - 1; pos >= 0; pos--) begin
         q = mag / p;
         mag = mag % p;
         if (showing || q != 0 || pos == 0) begin
            showing = 1'b1;
            codes.push_back(q < 10 ? zero_code[r.set] + q[CODE_W-1:0] : overflow_reg);
         end else if (r.mode == ALIGN_RIGHT) begin
            codes.push_back(space_code[r.set]);
         end
         p = p / 10;
      end
      expect_chars(codes);
   endfunction

   task automatic set_register(input csr_index_type index, input logic [CODE_W-1:0] data);
      req_valid <= 1'b0;
      while (awaited_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_CAPACITY:  capacity_reg = data[CAP_W-1:0];
         CSR_JP_ZERO:   zero_code[SET_JP] = data;
         CSR_EN_ZERO:   zero_code[SET_EN] = data;
         CSR_JP_HYPHEN: hyphen_code[SET_JP] = data;
         CSR_EN_HYPHEN: hyphen_code[SET_EN] = data;
         CSR_JP_SPACE:  space_code[SET_JP] = data;
         CSR_EN_SPACE:  space_code[SET_EN] = data;
         CSR_OVERFLOW:  overflow_reg = data;
         default: ;
      endcase
   endtask

   task automatic send_request(input format_request_type r, input row_kind_type kind,
                               input logic [8*11-1:0] text);
      logic [CODE_W-1:0] text_codes [$];
      int gap;
      gap = (!steady && $urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= r.value;
      req_digit_count <= r.count;
      req_align_mode <= r.mode;
      req_char_set <= r.set;
      do @(posedge clock); while (req_stall);
      case (kind)
         ROW_TEXT: begin
            for (int i = 10; i >= 0; i--) begin
               if (text[8*i +: 8] != 8'h00) text_codes.push_back({8'h00, text[8*i +: 8]});
            end
            expect_chars(text_codes);
         end
         ROW_ERROR: expect_overflow_error();
         default: format_decimal(r);
      endcase
   endtask

   initial begin
      char_beat_type want;
      int hold_cycles;
      bit pressure_done;
      hold_cycles = 0;
      pressure_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (awaited_chars.size() == 0) begin
               $error("unexpected beat: char_code %0d last %0d error %0d",
                      rsp_char_code, rsp_last, rsp_error);
               fault_count++;
            end else begin
               want = awaited_chars.pop_front();
               if (rsp_char_code !== want.code) begin
                  $error("char_code: expected %0d, got %0d", want.code, rsp_char_code);
                  fault_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fault_count++;
               end
               if (rsp_error !== want.error) begin
                  $error("error: expected %0d, got %0d", want.error, rsp_error);
                  fault_count++;
               end
            end
         end
         if (pressure_due && !pressure_done) begin
            pressure_done = 1'b1;
            hold_cycles = HOLD_OFF_CYCLES;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && $urandom_range(0, 9) == 0;
         end
      end
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      format_request_type r;
      logic [VALUE_W-1:0] v;
      logic [CODE_W-1:0] data;
      int unsigned p;
      capacity_reg = CAPACITY_RST;
      zero_code[SET_JP] = JP_ZERO_RST;
      zero_code[SET_EN] = EN_ZERO_RST;
      hyphen_code[SET_JP] = JP_HYPHEN_RST;
      hyphen_code[SET_EN] = EN_HYPHEN_RST;
      space_code[SET_JP] = JP_SPACE_RST;
      space_code[SET_EN] = EN_SPACE_RST;
      overflow_reg = OVERFLOW_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_WRITE) begin
            set_register(directed_rows[k].index, directed_rows[k].data);
         end else begin
            send_request(directed_rows[k].request, directed_rows[k].kind, directed_rows[k].text);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         for (int k = 0; k < 8; k++) begin
            if (csr_index_type'(k) == CSR_CAPACITY) begin
               data[15:8] = 8'($urandom);
               case (phase)
                  0: data[7:0] = 8'hFF;
                  1: data[7:0] = 8'($urandom_range(1, 13));
                  2: data[7:0] = CAPACITY_RST;
                  default: data[7:0] = 8'($urandom_range(0, 255));
               endcase
            end else begin
               case ($urandom_range(0, 3))
                  0: data = 16'h0000;
                  1: data = 16'hFFFF;
                  default: data = CODE_W'($urandom);
               endcase
            end
            set_register(csr_index_type'(k), data);
         end
         // The second phase runs without idling; the third starts with a long hold-off.
         steady = (phase == 1);
         pressure_due = (phase == 2);
         repeat (ITEMS_PER_PHASE) begin
            case ($urandom_range(0, 4))
               0: v = $urandom;
               1: v = $urandom_range(0, 999);
               2: begin
                  p = 1;
                  repeat ($urandom_range(0, 9)) p = p * 10;
                  v = p - 1 + $urandom_range(0, 2);
               end
               3: begin
                  case ($urandom_range(0, 2))
                     0: v = 32'h8000_0000;
                     1: v = 32'h7FFF_FFFF;
                     default: v = '0;
                  endcase
               end
               default: v = $urandom >> $urandom_range(0, 31);
            endcase
            if ($urandom_range(0, 2) == 0) v = 32'd0 - v;
            r.value = v;
            r.count = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, 15))
                                                  : COUNT_W'($urandom_range(1, 10));
            r.mode = MODE_W'($urandom_range(0, 3));
            r.set = 1'($urandom_range(0, 1));
            send_request(r, ROW_PREDICT, '0);
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (awaited_chars.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fault_count == 0 && awaited_chars.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
